// ===== design/wavhp_pkg.sv =====
// Package for the WAV header parser: tag constants, header byte positions,
// parse phase and error code types. No dependencies.

package wavhp_pkg;

    // Little-endian tags as they sit in the four-byte shift window
    localparam logic [31:0] TAG_RIFF     = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE     = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] MONO_CHANS   = 16'd1;
    localparam logic [15:0] BITS_8       = 16'd8;

    // Header byte index at which each field's last byte arrives
    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] POS_RIFF     = 6'd3;
    localparam logic [POS_W-1:0] POS_WAVE     = 6'd11;
    localparam logic [POS_W-1:0] POS_FMT      = 6'd15;
    localparam logic [POS_W-1:0] POS_FMT_SIZE = 6'd19;
    localparam logic [POS_W-1:0] POS_FORMAT   = 6'd21;
    localparam logic [POS_W-1:0] POS_CHANS    = 6'd23;
    localparam logic [POS_W-1:0] POS_RATE     = 6'd27;
    localparam logic [POS_W-1:0] POS_BITS     = 6'd35;
    localparam logic [POS_W-1:0] POS_DATA     = 6'd39;
    localparam logic [POS_W-1:0] POS_LAST     = 6'd43;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DONE    = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_RIFF  = 3'd1,
        ERR_NO_WAVE  = 3'd2,
        ERR_NO_FMT   = 3'd3,
        ERR_FMT_SMALL = 3'd4,
        ERR_NOT_PCM  = 3'd5,
        ERR_NO_DATA  = 3'd6,
        ERR_TRUNC    = 3'd7
    } err_t;

    // Sample format codes: bit 1 stereo (channel count not one), bit 0 sixteen-bit (bits not eight)
    localparam logic [1:0] FMT_MONO8    = 2'd0;
    localparam logic [1:0] FMT_MONO16   = 2'd1;
    localparam logic [1:0] FMT_STEREO8  = 2'd2;
    localparam logic [1:0] FMT_STEREO16 = 2'd3;

endpackage

// ===== design/wav_header_parser_top.sv =====
// WAV header parser top level: byte stream in, one result transfer per byte out.
// Depends on wavhp_pkg.

// Usage
//   Slave channel: one byte of a WAV file per transfer. s_axis_tuser marks the
//   first byte of a file (restarts the parse in any phase), s_axis_tlast the
//   final byte. The 44-byte PCM header is checked and its fields captured;
//   after it, payload bytes pass through.
//   Master channel: exactly one result transfer per input transfer, in order.
//   m_axis_tuser flags a header-complete or a payload result, m_axis_tlast
//   marks the final payload byte (declared length reached or file end).
//   Captured fields and the latched error code ride along on every result.
//   Latency: the result is presented the cycle after its byte is accepted.
//   Throughput: one byte per clock while m_axis_tready is high; each byte needs
//   one pass of compares, a byte shift and a 32-bit decrement ahead of the output register.
//   Stall: the output register holds its result while m_axis_tready is low;
//   s_axis_tready is high when that register is empty or being drained, so a
//   new byte is taken in the same cycle the previous result leaves.
//   Reset (aresetn low, synchronous): parse state, captured fields and error
//   are cleared and the output register is emptied.
//   After an error, a header with no payload to follow, or the final payload byte,
//   bytes are consumed and answered with held values only, until the next first-byte marker.

module wav_header_parser_top (
    input  logic         aclk,
    input  logic         aresetn,
    // slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] first_byte
    input  logic         s_axis_tlast,   // last_byte
    // master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] channel_count, [47:16] sample_rate, [63:48] bits_per_sample,
    // [65:64] sample_format, [97:66] data_length, [105:98] payload_byte,
    // [108:106] error_code, [111:109] zero
    output logic [111:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [0] header_ready, [1] payload_valid
    output logic         m_axis_tlast    // payload_last
);

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    logic [wavhp_pkg::POS_W-1:0] pos_reg, pos_next;
    wavhp_pkg::phase_t           phase_reg, phase_next;
    logic [31:0]                 shift_reg, shift_next;
    logic [15:0]                 chans_reg, chans_next;
    logic [31:0]                 rate_reg, rate_next;
    logic [15:0]                 bits_reg, bits_next;
    logic [31:0]                 remain_reg, remain_next;
    wavhp_pkg::err_t             err_reg, err_next;

    // Output register
    logic         out_valid_reg;
    logic         ready_reg, ready_next;
    logic         pvalid_reg, pvalid_next;
    logic         plast_reg, plast_next;
    logic [31:0]  dlen_reg, dlen_next;
    logic [7:0]   pbyte_reg, pbyte_next;
    logic [1:0]   sfmt_reg, sfmt_next;
    logic [15:0]  chans_out_reg;
    logic [31:0]  rate_out_reg;
    logic [15:0]  bits_out_reg;
    wavhp_pkg::err_t err_out_reg;

    // State as seen by this byte (a first byte starts from cleared state)
    logic [wavhp_pkg::POS_W-1:0] pos_eff;
    wavhp_pkg::phase_t           phase_eff;
    logic [31:0]                 shift_eff, shift_new;
    logic [15:0]                 hi16;
    logic                        chk_fail;
    wavhp_pkg::err_t             chk_code;

    logic in_fire;
    logic first_b, last_b;

    assign first_b = s_axis_tuser;
    assign last_b  = s_axis_tlast;

    // output register empty or draining this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        pos_eff   = first_b ? '0 : pos_reg;
        phase_eff = first_b ? wavhp_pkg::PH_HEADER : phase_reg;
        shift_eff = first_b ? '0 : shift_reg;

        shift_new = {s_axis_tdata, shift_eff[31:8]};
        hi16      = shift_new[31:16];

        pos_next    = pos_eff;
        phase_next  = phase_eff;
        shift_next  = shift_eff;
        chans_next  = first_b ? '0 : chans_reg;
        rate_next   = first_b ? '0 : rate_reg;
        bits_next   = first_b ? '0 : bits_reg;
        remain_next = first_b ? '0 : remain_reg;
        err_next    = first_b ? wavhp_pkg::ERR_NONE : err_reg;

        ready_next  = 1'b0;
        pvalid_next = 1'b0;
        plast_next  = 1'b0;
        dlen_next   = '0;
        pbyte_next  = '0;
        chk_fail    = 1'b0;
        chk_code    = wavhp_pkg::ERR_NONE;

        case (phase_eff)
            wavhp_pkg::PH_HEADER: begin
                shift_next = shift_new;
                case (pos_eff)
                    wavhp_pkg::POS_RIFF: begin
                        chk_fail = (shift_new != wavhp_pkg::TAG_RIFF);
                        chk_code = wavhp_pkg::ERR_NO_RIFF;
                    end
                    wavhp_pkg::POS_WAVE: begin
                        chk_fail = (shift_new != wavhp_pkg::TAG_WAVE);
                        chk_code = wavhp_pkg::ERR_NO_WAVE;
                    end
                    wavhp_pkg::POS_FMT: begin
                        chk_fail = (shift_new != wavhp_pkg::TAG_FMT);
                        chk_code = wavhp_pkg::ERR_NO_FMT;
                    end
                    wavhp_pkg::POS_FMT_SIZE: begin
                        chk_fail = (shift_new < wavhp_pkg::FMT_MIN_SIZE);
                        chk_code = wavhp_pkg::ERR_FMT_SMALL;
                    end
                    wavhp_pkg::POS_FORMAT: begin
                        chk_fail = (hi16 != wavhp_pkg::FMT_PCM);
                        chk_code = wavhp_pkg::ERR_NOT_PCM;
                    end
                    wavhp_pkg::POS_CHANS: chans_next = hi16;
                    wavhp_pkg::POS_RATE:  rate_next  = shift_new;
                    wavhp_pkg::POS_BITS:  bits_next  = hi16;
                    wavhp_pkg::POS_DATA: begin
                        chk_fail = (shift_new != wavhp_pkg::TAG_DATA);
                        chk_code = wavhp_pkg::ERR_NO_DATA;
                    end
                    default: ;
                endcase

                if (chk_fail) begin
                    // the check's own code wins over truncation
                    err_next   = chk_code;
                    phase_next = wavhp_pkg::PH_DONE;
                end else if (pos_eff >= wavhp_pkg::POS_LAST) begin
                    ready_next  = 1'b1;
                    dlen_next   = shift_new;
                    remain_next = shift_new;
                    pos_next    = '0;
                    phase_next  = (shift_new == '0 || last_b) ? wavhp_pkg::PH_DONE
                                                               : wavhp_pkg::PH_PAYLOAD;
                end else if (last_b) begin
                    err_next   = wavhp_pkg::ERR_TRUNC;
                    phase_next = wavhp_pkg::PH_DONE;
                end else begin
                    pos_next = pos_eff + 6'd1;
                end
            end
            wavhp_pkg::PH_PAYLOAD: begin
                // a first byte never lands in the payload phase
                pvalid_next = 1'b1;
                pbyte_next  = s_axis_tdata;
                remain_next = remain_reg - 32'd1;
                if (remain_next == '0 || last_b) begin
                    plast_next = 1'b1;
                    phase_next = wavhp_pkg::PH_DONE;
                end
            end
            default: ;
        endcase

        sfmt_next = {chans_next != wavhp_pkg::MONO_CHANS, bits_next != wavhp_pkg::BITS_8};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            phase_reg  <= wavhp_pkg::PH_HEADER;
            shift_reg  <= '0;
            chans_reg  <= '0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            remain_reg <= '0;
            err_reg    <= wavhp_pkg::ERR_NONE;
        end else if (in_fire) begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            chans_reg  <= chans_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            remain_reg <= remain_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with each accepted byte
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ready_reg     <= ready_next;
            pvalid_reg    <= pvalid_next;
            plast_reg     <= plast_next;
            dlen_reg      <= dlen_next;
            pbyte_reg     <= pbyte_next;
            sfmt_reg      <= sfmt_next;
            chans_out_reg <= chans_next;
            rate_out_reg  <= rate_next;
            bits_out_reg  <= bits_next;
            err_out_reg   <= err_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {pvalid_reg, ready_reg};
    assign m_axis_tlast  = plast_reg;
    assign m_axis_tdata  = {3'b000, err_out_reg, pbyte_reg, dlen_reg, sfmt_reg,
                            bits_out_reg, rate_out_reg, chans_out_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_payload_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("header_ready and payload_valid in one result");

    a_last_needs_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[1])
        else $error("payload_last without payload byte");

    a_error_means_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != wavhp_pkg::ERR_NONE) |-> (phase_reg == wavhp_pkg::PH_DONE))
        else $error("latched error while still parsing");

    a_done_is_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !s_axis_tuser && phase_reg == wavhp_pkg::PH_DONE)
        |=> (m_axis_tuser == 2'b00 && !m_axis_tlast))
        else $error("finished parser produced header or payload flag");

endmodule

// ===== test/wav_header_parser_top_test.sv =====
// Testbench for wav_header_parser_top: byte streams of WAV files in, per-byte results
// checked against a predictor of the header parse. Depends on wavhp_pkg and the top level.
`timescale 1ns / 100ps

module wav_header_parser_top_test;

    // Abandon the run after this many cycles with no transfer on either side
    localparam int STALL_LIMIT = 2000;
    localparam int HDR_BYTES   = 44;

    // One input byte with its file markers
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } byte_item_t;

    // Fields of one result transfer
    typedef struct {
        logic        ready;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [1:0]  fmt;
        logic [31:0] dlen;
        logic        pvalid;
        logic [7:0]  pbyte;
        logic        plast;
        logic [2:0]  err;
    } parse_result_t;

    // Scoreboard: tracks the parse state and holds the results still owed by the block
    class wav_parse_scoreboard;
        logic [5:0]        position;
        wavhp_pkg::phase_t phase;
        logic [31:0]       window;        // last four bytes, newest in the top byte
        logic [15:0]       chans_held;
        logic [31:0]       rate_held;
        logic [15:0]       bits_held;
        logic [31:0]       remaining;
        wavhp_pkg::err_t   err_held;
        parse_result_t     awaited_results[$];
        int                mismatches;
        int                results_seen;

        function new();
            clear_parse();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void clear_parse();
            position   = '0;
            phase      = wavhp_pkg::PH_HEADER;
            window     = '0;
            chans_held = '0;
            rate_held  = '0;
            bits_held  = '0;
            remaining  = '0;
            err_held   = wavhp_pkg::ERR_NONE;
        endfunction

        function void latch_error(wavhp_pkg::err_t code);
            err_held = code;
            phase    = wavhp_pkg::PH_DONE;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Advance the parse by one accepted byte and queue the result it owes
        function void note_byte(logic [7:0] b, logic first, logic last);
            parse_result_t r;
            logic [15:0]   hi16;
            r = '{default: '0};
            if (first)
                clear_parse();
            if (phase == wavhp_pkg::PH_HEADER) begin
                window = {b, window[31:8]};
                hi16   = window[31:16];
                case (position)
                    wavhp_pkg::POS_RIFF:
                        if (window != wavhp_pkg::TAG_RIFF) latch_error(wavhp_pkg::ERR_NO_RIFF);
                    wavhp_pkg::POS_WAVE:
                        if (window != wavhp_pkg::TAG_WAVE) latch_error(wavhp_pkg::ERR_NO_WAVE);
                    wavhp_pkg::POS_FMT:
                        if (window != wavhp_pkg::TAG_FMT) latch_error(wavhp_pkg::ERR_NO_FMT);
                    wavhp_pkg::POS_FMT_SIZE:
                        if (window < wavhp_pkg::FMT_MIN_SIZE)
                            latch_error(wavhp_pkg::ERR_FMT_SMALL);
                    wavhp_pkg::POS_FORMAT:
                        if (hi16 != wavhp_pkg::FMT_PCM) latch_error(wavhp_pkg::ERR_NOT_PCM);
                    wavhp_pkg::POS_CHANS: chans_held = hi16;
                    wavhp_pkg::POS_RATE:  rate_held = window;
                    wavhp_pkg::POS_BITS:  bits_held = hi16;
                    wavhp_pkg::POS_DATA:
                        if (window != wavhp_pkg::TAG_DATA) latch_error(wavhp_pkg::ERR_NO_DATA);
                    default: ;
                endcase
                // a failed check wins over truncation on the same byte
                if (phase == wavhp_pkg::PH_HEADER) begin
                    if (position >= wavhp_pkg::POS_LAST) begin
                        r.ready   = 1'b1;
                        r.dlen    = window;
                        remaining = window;
                        position  = '0;
                        phase     = (window == 32'd0 || last) ? wavhp_pkg::PH_DONE
                                                              : wavhp_pkg::PH_PAYLOAD;
                    end else if (last) begin
                        latch_error(wavhp_pkg::ERR_TRUNC);
                    end else begin
                        position = position + 6'd1;
                    end
                end
            end else if (phase == wavhp_pkg::PH_PAYLOAD) begin
                r.pvalid  = 1'b1;
                r.pbyte   = b;
                remaining = remaining - 32'd1;
                if (remaining == 32'd0 || last) begin
                    r.plast = 1'b1;
                    phase   = wavhp_pkg::PH_DONE;
                end
            end
            r.chans = chans_held;
            r.rate  = rate_held;
            r.bits  = bits_held;
            if (chans_held == wavhp_pkg::MONO_CHANS)
                r.fmt = (bits_held == wavhp_pkg::BITS_8) ? wavhp_pkg::FMT_MONO8
                                                         : wavhp_pkg::FMT_MONO16;
            else
                r.fmt = (bits_held == wavhp_pkg::BITS_8) ? wavhp_pkg::FMT_STEREO8
                                                         : wavhp_pkg::FMT_STEREO16;
            r.err = err_held;
            awaited_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("%0t result %0d: %s", $time, results_seen, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // Compare one accepted result with the oldest one owed
        task check_result(logic [111:0] data, logic [1:0] flags, logic tail);
            parse_result_t e;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
                return;
            end
            e = awaited_results.pop_front();
            check_field("header_ready",    flags[0],       e.ready);
            check_field("payload_valid",   flags[1],       e.pvalid);
            check_field("payload_last",    tail,           e.plast);
            check_field("channel_count",   data[15:0],     e.chans);
            check_field("sample_rate",     data[47:16],    e.rate);
            check_field("bits_per_sample", data[63:48],    e.bits);
            check_field("sample_format",   data[65:64],    e.fmt);
            check_field("data_length",     data[97:66],    e.dlen);
            check_field("payload_byte",    data[105:98],   e.pbyte);
            check_field("error_code",      data[108:106],  e.err);
            check_field("tdata padding",   data[111:109],  32'd0);
        endtask
    endclass

    // ---------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ---------------------------------------------------------------
    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = '0;
    logic         s_axis_tuser  = 1'b0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // Idle percentages of the current phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    wav_parse_scoreboard sb;
    byte_item_t          stim_q[$];
    logic [7:0]          hdr_bytes [HDR_BYTES];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    wav_header_parser_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Receiver: back-pressure drawn fresh every falling edge
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result side is sampled at the rising edge, before the edge's updates land
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Watchdog: only cycles without any transfer count toward the limit
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("wav_header_parser_top_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------

    // Write a little-endian field into the header image
    task automatic put_le(int at, logic [31:0] value, int nbytes);
        for (int k = 0; k < nbytes; k++)
            hdr_bytes[at + k] = value[8*k +: 8];
    endtask

    // Well-formed 44-byte header; the RIFF size and the skipped byte-rate and
    // block-align bytes are random filler
    task automatic build_header(logic [15:0] chans, logic [31:0] rate, logic [15:0] bits,
                                logic [31:0] fsize, logic [31:0] dlen);
        for (int i = 0; i < HDR_BYTES; i++)
            hdr_bytes[i] = 8'($urandom);
        put_le(0,  wavhp_pkg::TAG_RIFF, 4);
        put_le(8,  wavhp_pkg::TAG_WAVE, 4);
        put_le(12, wavhp_pkg::TAG_FMT,  4);
        put_le(16, fsize,    4);
        put_le(20, 32'(wavhp_pkg::FMT_PCM), 2);
        put_le(22, 32'(chans),   2);
        put_le(24, rate,     4);
        put_le(34, 32'(bits),    2);
        put_le(36, wavhp_pkg::TAG_DATA, 4);
        put_le(40, dlen,     4);
    endtask

    // Break the header so that exactly the named check fails
    task automatic break_check(wavhp_pkg::err_t code);
        logic [15:0] bad_fmt;
        case (code)
            wavhp_pkg::ERR_NO_RIFF:
                hdr_bytes[$urandom_range(0, 3)]   ^= 8'($urandom_range(1, 255));
            wavhp_pkg::ERR_NO_WAVE:
                hdr_bytes[$urandom_range(8, 11)]  ^= 8'($urandom_range(1, 255));
            wavhp_pkg::ERR_NO_FMT:
                hdr_bytes[$urandom_range(12, 15)] ^= 8'($urandom_range(1, 255));
            wavhp_pkg::ERR_FMT_SMALL: put_le(16, 32'($urandom_range(0, 15)), 4);
            wavhp_pkg::ERR_NOT_PCM: begin
                bad_fmt = 16'($urandom);
                if (bad_fmt == wavhp_pkg::FMT_PCM)
                    bad_fmt = 16'd0;
                put_le(20, 32'(bad_fmt), 2);
            end
            wavhp_pkg::ERR_NO_DATA:
                hdr_bytes[$urandom_range(36, 39)] ^= 8'($urandom_range(1, 255));
            default: ;
        endcase
    endtask

    // Queue hdr_len header bytes followed by pay_len random payload bytes
    task automatic queue_file(int hdr_len, int pay_len, bit with_first, bit with_end);
        byte_item_t item;
        int         total;
        total = hdr_len + pay_len;
        for (int i = 0; i < total; i++) begin
            item.data  = (i < hdr_len) ? hdr_bytes[i] : 8'($urandom);
            item.first = with_first && (i == 0);
            item.last  = with_end && (i == total - 1);
            stim_q.push_back(item);
        end
    endtask

    // Stray bytes with random markers
    task automatic queue_noise(int count);
        byte_item_t item;
        for (int i = 0; i < count; i++) begin
            item.data  = 8'($urandom);
            item.first = ($urandom_range(0, 19) == 0);
            item.last  = ($urandom_range(0, 9) == 0);
            stim_q.push_back(item);
        end
    endtask

    task automatic queue_directed();
        int fail_len;
        // header straight after reset, no first-byte marker; payload ends by
        // declared length and file end together
        build_header(16'd1, 32'd8000, 16'd8, 32'd16, 32'd4);
        queue_file(HDR_BYTES, 4, 1'b0, 1'b1);
        // restart in the middle of a header by the next file
        build_header(16'd2, 32'd96000, 16'd16, 32'd16, 32'd3);
        queue_file(30, 0, 1'b1, 1'b0);
        // stereo 16-bit, file ends before declared length
        build_header(16'd2, 32'd44100, 16'd16, 32'd18, 32'd10);
        queue_file(HDR_BYTES, 3, 1'b1, 1'b1);
        // all-ones fields, zero declared length, trailing bytes ignored
        build_header(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        queue_file(HDR_BYTES, 3, 1'b1, 1'b1);
        // all-zero fields, huge length, restart in mid-payload by the next file
        build_header(16'd0, 32'd0, 16'd0, 32'd16, 32'hFFFF_FFFF);
        queue_file(HDR_BYTES, 5, 1'b1, 1'b0);
        // file end on the byte that completes the header
        build_header(16'd2, 32'd48000, 16'd8, 32'd16, 32'd7);
        queue_file(HDR_BYTES, 0, 1'b1, 1'b1);
        // payload longer than declared: the surplus is ignored
        build_header(16'd1, 32'd11025, 16'd16, 32'd16, 32'd2);
        queue_file(HDR_BYTES, 5, 1'b1, 1'b1);
        // each header check failing in turn, one ignored byte after it
        for (int c = wavhp_pkg::ERR_NO_RIFF; c <= wavhp_pkg::ERR_NO_DATA; c++) begin
            build_header(16'd2, 32'd32000, 16'd16, 32'd16, 32'd3);
            break_check(wavhp_pkg::err_t'(c));
            case (wavhp_pkg::err_t'(c))
                wavhp_pkg::ERR_NO_RIFF:   fail_len = int'(wavhp_pkg::POS_RIFF) + 2;
                wavhp_pkg::ERR_NO_WAVE:   fail_len = int'(wavhp_pkg::POS_WAVE) + 2;
                wavhp_pkg::ERR_NO_FMT:    fail_len = int'(wavhp_pkg::POS_FMT) + 2;
                wavhp_pkg::ERR_FMT_SMALL: fail_len = int'(wavhp_pkg::POS_FMT_SIZE) + 2;
                wavhp_pkg::ERR_NOT_PCM:   fail_len = int'(wavhp_pkg::POS_FORMAT) + 2;
                wavhp_pkg::ERR_NO_DATA:   fail_len = int'(wavhp_pkg::POS_DATA) + 2;
                default:                  fail_len = HDR_BYTES;
            endcase
            queue_file(fail_len, 0, 1'b1, 1'b1);
        end
        // format chunk one below the minimum
        build_header(16'd1, 32'd8000, 16'd8, 32'd15, 32'd3);
        queue_file(int'(wavhp_pkg::POS_FMT_SIZE) + 2, 0, 1'b1, 1'b1);
        // file cut short inside the header
        build_header(16'd1, 32'd8000, 16'd8, 32'd16, 32'd3);
        queue_file(20, 0, 1'b1, 1'b1);
        // failed tag and file end on the same byte: the tag error wins
        build_header(16'd1, 32'd8000, 16'd8, 32'd16, 32'd3);
        break_check(wavhp_pkg::ERR_NO_WAVE);
        hdr_bytes[11] ^= 8'h01;
        queue_file(12, 0, 1'b1, 1'b1);
        // bytes after the finish with no first-byte marker
        queue_file(0, 4, 1'b0, 1'b1);
    endtask

    // Mostly well-formed files with random content; the rest broken or noise
    task automatic queue_random_file();
        int          kind;
        int          pay_len;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] fsize;
        logic [31:0] dlen;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       chans = 16'($urandom);
            1:       chans = 16'd1;
            default: chans = 16'd2;
        endcase
        case ($urandom_range(0, 3))
            0:       bits = 16'($urandom);
            1:       bits = 16'd8;
            default: bits = 16'd16;
        endcase
        fsize = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'd16;
        if (fsize < wavhp_pkg::FMT_MIN_SIZE)
            fsize = fsize + wavhp_pkg::FMT_MIN_SIZE;
        dlen = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 12));
        build_header(chans, 32'($urandom), bits, fsize, dlen);
        pay_len = (dlen > 32'd40) ? $urandom_range(0, 16) : $urandom_range(0, int'(dlen) + 3);
        if (kind < 60) begin
            queue_file(HDR_BYTES, pay_len, 1'b1, $urandom_range(0, 4) != 0);
        end else if (kind < 80) begin
            break_check(wavhp_pkg::err_t'($urandom_range(wavhp_pkg::ERR_NO_RIFF,
                                                         wavhp_pkg::ERR_NO_DATA)));
            queue_file(HDR_BYTES, $urandom_range(0, 4), 1'b1, $urandom_range(0, 1));
        end else if (kind < 90) begin
            queue_file($urandom_range(1, HDR_BYTES - 1), 0, 1'b1, $urandom_range(0, 3) != 0);
        end else begin
            queue_noise($urandom_range(1, 20));
        end
    endtask

    // ---------------------------------------------------------------
    // Sender: inputs change at the falling edge, acceptance seen at the rising edge
    // ---------------------------------------------------------------
    task automatic send_bytes();
        byte_item_t item;
        while (stim_q.size() > 0) begin
            item = stim_q.pop_front();
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= item.data;
            s_axis_tuser  <= item.first;
            s_axis_tlast  <= item.last;
            @(posedge aclk);
            while (!s_axis_tready)
                @(posedge aclk);
            sb.note_byte(item.data, item.first, item.last);
            @(negedge aclk);
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit with_directed);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_directed)
            queue_directed();
        // random part of the idling phases: files until at least 30 bytes are queued
        target = with_directed ? stim_q.size() : 30;
        while (stim_q.size() < target)
            queue_random_file();
        send_bytes();
    endtask

    initial begin
        sb = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_phase(0, 0, 1'b1);      // directed cases, no idling
        run_phase(84, 0, 1'b0);     // sender mostly idle
        run_phase(0, 84, 1'b0);     // receiver mostly stalling
        run_phase(9, 9, 1'b0);      // light idling on both sides
        s_axis_tvalid <= 1'b0;

        // drain: every owed result must come out; watchdog catches a hang
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("wav_header_parser_top_test: clean");
        else
            $display("wav_header_parser_top_test: errors");
        $finish;
    end

endmodule
